FILE: hw/rtl/y86_instruction_executor_core_defines.svh
// assertion macros shared by the checker
`ifndef Y86_INSTRUCTION_EXECUTOR_CORE_DEFINES_SVH
`define Y86_INSTRUCTION_EXECUTOR_CORE_DEFINES_SVH

// same-cycle implication
`define Y86_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("y86 core assertion failed");

// next-cycle implication
`define Y86_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("y86 core assertion failed");

`endif

FILE: hw/rtl/y86ie_pkg.sv
package y86ie_pkg;

	typedef struct packed {
		logic        command;
		logic [11:0] address;
		logic [7:0]  data_byte;
	} y86ie_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] program_counter;
		logic        zero_flag;
		logic        sign_flag;
		logic        overflow_flag;
		logic        dest_valid;
		logic [3:0]  dest_reg;
		logic [63:0] dest_value;
		logic [63:0] stack_pointer;
		logic [63:0] fault_address;
	} y86ie_result_t;

	localparam logic [1:0] ST_AOK = 2'd0;
	localparam logic [1:0] ST_HLT = 2'd1;
	localparam logic [1:0] ST_ADR = 2'd2;
	localparam logic [1:0] ST_INS = 2'd3;

	localparam logic [3:0] I_HALT  = 4'h0;
	localparam logic [3:0] I_NOP   = 4'h1;
	localparam logic [3:0] I_CMOV  = 4'h2;
	localparam logic [3:0] I_IRMOV = 4'h3;
	localparam logic [3:0] I_RMMOV = 4'h4;
	localparam logic [3:0] I_MRMOV = 4'h5;
	localparam logic [3:0] I_OPQ   = 4'h6;
	localparam logic [3:0] I_JXX   = 4'h7;
	localparam logic [3:0] I_CALL  = 4'h8;
	localparam logic [3:0] I_RET   = 4'h9;
	localparam logic [3:0] I_PUSH  = 4'hA;
	localparam logic [3:0] I_POP   = 4'hB;

	localparam logic [3:0] FN_ADD = 4'h0;
	localparam logic [3:0] FN_SUB = 4'h1;
	localparam logic [3:0] FN_AND = 4'h2;
	localparam logic [3:0] FN_XOR = 4'h3;
	localparam logic [3:0] FN_ALU_MAX  = 4'h3;
	localparam logic [3:0] FN_COND_MAX = 4'h6;

	localparam logic [3:0] FN_C_ALWAYS = 4'h0;
	localparam logic [3:0] FN_C_LE     = 4'h1;
	localparam logic [3:0] FN_C_LT     = 4'h2;
	localparam logic [3:0] FN_C_EQ     = 4'h3;
	localparam logic [3:0] FN_C_NE     = 4'h4;
	localparam logic [3:0] FN_C_GE     = 4'h5;

	localparam logic [3:0] REG_NONE = 4'hF;
	localparam logic [3:0] RSP_IDX  = 4'd4;
	localparam int         WORD_BYTES = 8;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_CLEAR,
		OP_CAPTURE,
		OP_RD_PC,
		OP_LATCH_OP,
		OP_RD_NPC,
		OP_LATCH_REG,
		OP_SETUP_NPC,
		OP_WORD_READ,
		OP_LATCH_VALC,
		OP_READ_A,
		OP_READ_B,
		OP_EXEC,
		OP_SETUP_T,
		OP_WORD_WRITE,
		OP_COMMIT,
		OP_ADR_PC,
		OP_ADR_NPC,
		OP_ADR_T,
		OP_SET_INS,
		OP_SET_HLT,
		OP_PUBLISH
	} dp_op_t;

	typedef struct packed {
		logic clr_last;
		logic is_store;
		logic stopped;
		logic pc_bad;
		logic need_reg;
		logic need_valc;
		logic npc_byte_bad;
		logic npc_word_bad;
		logic ins_bad;
		logic is_halt;
		logic mem_access;
		logic mem_load;
		logic addr_bad;
		logic word_rd_done;
		logic word_wr_done;
	} dp_status_t;

endpackage

FILE: hw/rtl/y86ie_ram.sv
module y86ie_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

FILE: hw/rtl/y86ie_dp.sv
module y86ie_dp #(
	parameter int MEM_BYTES = 4096
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  y86ie_pkg::dp_op_t        op,
	input  y86ie_pkg::y86ie_item_t   item,
	output y86ie_pkg::dp_status_t    status,
	output y86ie_pkg::y86ie_result_t result
);
	import y86ie_pkg::*;

	localparam int AW = $clog2(MEM_BYTES);
	localparam logic [63:0] MemLimit  = 64'(MEM_BYTES);
	localparam logic [63:0] WordLimit = 64'(MEM_BYTES - WORD_BYTES);
	localparam logic [3:0]  CntRdDone = 4'(WORD_BYTES);
	localparam logic [3:0]  CntWrDone = 4'(WORD_BYTES - 1);
	localparam logic [63:0] WordStep  = 64'(WORD_BYTES);

	// architectural state
	logic [63:0] pc_q;
	logic [63:0] regs_q [15];
	logic        zf_q, sf_q, of_q;
	logic [1:0]  stat_q;
	logic [AW-1:0] maddr_q;

	// per-step working registers
	logic        cmd_q;
	logic [3:0]  icode_q, fn_q, ra_q, rb_q;
	logic [63:0] valc_q, npc_q, a_q, b_q, t_q, word_q;
	logic [2:0]  ncc_q;
	logic [3:0]  cnt_q;
	logic        dv_q;
	logic [3:0]  dr_q;
	logic [63:0] dval_q, fault_q;
	y86ie_result_t result_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]    ram_wdata, ram_rdata;
	logic [63:0]   item_addr;
	logic [3:0]    ridx;
	logic [63:0]   rd_val, sp, alu, exec_t;
	logic [2:0]    ncc;
	logic          cond;

	function automatic logic cond_holds(logic [3:0] fn, logic zf, logic sf, logic of);
		logic lt;
		lt = sf ^ of;
		case (fn)
			FN_C_ALWAYS: cond_holds = 1'b1;
			FN_C_LE:     cond_holds = lt | zf;
			FN_C_LT:     cond_holds = lt;
			FN_C_EQ:     cond_holds = zf;
			FN_C_NE:     cond_holds = !zf;
			FN_C_GE:     cond_holds = !lt;
			default:     cond_holds = !lt && !zf;
		endcase
	endfunction

	y86ie_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign item_addr = 64'(item.address);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = maddr_q;
		ram_wdata = word_q[7:0];
		ram_raddr = maddr_q;
		case (op)
			OP_CLEAR: begin
				ram_we    = 1'b1;
				ram_wdata = '0;
			end
			OP_CAPTURE: begin
				ram_we    = !item.command && (item_addr < MemLimit);
				ram_waddr = item_addr[AW-1:0];
				ram_wdata = item.data_byte;
			end
			OP_WORD_WRITE: ram_we = 1'b1;
			OP_RD_PC:      ram_raddr = pc_q[AW-1:0];
			OP_RD_NPC:     ram_raddr = npc_q[AW-1:0];
			default: ;
		endcase
	end

	// single register-file read port shared by the two operand reads
	assign ridx   = (op == OP_READ_B) ? rb_q : ra_q;
	assign rd_val = (ridx != REG_NONE) ? regs_q[ridx] : '0;
	assign sp     = regs_q[RSP_IDX];
	assign cond   = cond_holds(fn_q, zf_q, sf_q, of_q);

	always_comb begin
		case (fn_q)
			FN_ADD:  alu = b_q + a_q;
			FN_SUB:  alu = b_q - a_q;
			FN_AND:  alu = b_q & a_q;
			default: alu = b_q ^ a_q;
		endcase
		ncc[2] = (alu == '0);
		ncc[1] = alu[63];
		ncc[0] = ((fn_q == FN_ADD) && (a_q[63] == b_q[63]) && (alu[63] != a_q[63])) ||
			((fn_q == FN_SUB) && (a_q[63] != b_q[63]) && (alu[63] != b_q[63]));
	end

	always_comb begin
		unique case (icode_q) inside
			I_RMMOV, I_MRMOV: exec_t = valc_q + b_q;
			I_CALL, I_PUSH:   exec_t = sp - WordStep;
			I_RET, I_POP:     exec_t = sp;
			default:          exec_t = alu;
		endcase
	end

	always_comb begin
		status.clr_last     = (maddr_q == AW'(MEM_BYTES - 1));
		status.is_store     = !cmd_q;
		status.stopped      = (stat_q != ST_AOK);
		status.pc_bad       = (pc_q >= MemLimit);
		status.npc_byte_bad = (npc_q >= MemLimit);
		status.npc_word_bad = (npc_q > WordLimit);
		status.addr_bad     = (t_q > WordLimit);
		status.word_rd_done = (cnt_q == CntRdDone);
		status.word_wr_done = (cnt_q == CntWrDone);
		status.is_halt      = (icode_q == I_HALT);
		status.need_reg     = 1'b0;
		status.need_valc    = 1'b0;
		status.mem_access   = 1'b0;
		status.mem_load     = 1'b0;
		status.ins_bad      = 1'b0;
		unique case (icode_q) inside
			I_HALT, I_NOP: ;
			I_CMOV: begin
				status.need_reg = 1'b1;
				status.ins_bad  = (ra_q == REG_NONE) || (rb_q == REG_NONE) ||
					(fn_q > FN_COND_MAX);
			end
			I_IRMOV: begin
				status.need_reg  = 1'b1;
				status.need_valc = 1'b1;
				status.ins_bad   = (ra_q != REG_NONE) || (rb_q == REG_NONE);
			end
			I_RMMOV, I_MRMOV: begin
				status.need_reg   = 1'b1;
				status.need_valc  = 1'b1;
				status.mem_access = 1'b1;
				status.mem_load   = (icode_q == I_MRMOV);
				status.ins_bad    = (ra_q == REG_NONE) || (rb_q == REG_NONE);
			end
			I_OPQ: begin
				status.need_reg = 1'b1;
				status.ins_bad  = (ra_q == REG_NONE) || (rb_q == REG_NONE) ||
					(fn_q > FN_ALU_MAX);
			end
			I_JXX: begin
				status.need_valc = 1'b1;
				status.ins_bad   = (fn_q > FN_COND_MAX);
			end
			I_CALL: begin
				status.need_valc  = 1'b1;
				status.mem_access = 1'b1;
			end
			I_RET: begin
				status.mem_access = 1'b1;
				status.mem_load   = 1'b1;
			end
			I_PUSH, I_POP: begin
				status.need_reg   = 1'b1;
				status.mem_access = 1'b1;
				status.mem_load   = (icode_q == I_POP);
				status.ins_bad    = (ra_q == REG_NONE) || (rb_q != REG_NONE);
			end
			default: status.ins_bad = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q    <= '0;
			zf_q    <= 1'b1;
			sf_q    <= 1'b0;
			of_q    <= 1'b0;
			stat_q  <= ST_AOK;
			maddr_q <= '0;
			for (int i = 0; i < 15; i++) begin
				regs_q[i] <= '0;
			end
		end else begin
			case (op)
				OP_CLEAR:      maddr_q <= maddr_q + 1'b1;
				OP_SETUP_NPC:  maddr_q <= npc_q[AW-1:0];
				OP_SETUP_T:    maddr_q <= t_q[AW-1:0];
				OP_WORD_WRITE: maddr_q <= maddr_q + 1'b1;
				OP_WORD_READ: begin
					if (cnt_q != CntRdDone) begin
						maddr_q <= maddr_q + 1'b1;
					end
				end
				OP_ADR_PC, OP_ADR_NPC, OP_ADR_T: stat_q <= ST_ADR;
				OP_SET_INS: stat_q <= ST_INS;
				OP_SET_HLT: stat_q <= ST_HLT;
				OP_COMMIT: begin
					unique case (icode_q) inside
						I_NOP, I_RMMOV: pc_q <= npc_q;
						I_CMOV: begin
							pc_q <= npc_q;
							if (cond) begin
								regs_q[rb_q] <= a_q;
							end
						end
						I_IRMOV: begin
							regs_q[rb_q] <= valc_q;
							pc_q <= npc_q;
						end
						I_MRMOV: begin
							regs_q[ra_q] <= word_q;
							pc_q <= npc_q;
						end
						I_OPQ: begin
							{zf_q, sf_q, of_q} <= ncc_q;
							regs_q[rb_q] <= t_q;
							pc_q <= npc_q;
						end
						I_JXX: pc_q <= cond ? valc_q : npc_q;
						I_CALL: begin
							regs_q[RSP_IDX] <= t_q;
							pc_q <= valc_q;
						end
						I_RET: begin
							regs_q[RSP_IDX] <= t_q + WordStep;
							pc_q <= word_q;
						end
						I_PUSH: begin
							regs_q[RSP_IDX] <= t_q;
							pc_q <= npc_q;
						end
						I_POP: begin
							// popq %rsp keeps the popped value, not the bumped pointer
							if (ra_q != RSP_IDX) begin
								regs_q[RSP_IDX] <= t_q + WordStep;
							end
							regs_q[ra_q] <= word_q;
							pc_q <= npc_q;
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_CAPTURE: begin
				cmd_q   <= item.command;
				dv_q    <= 1'b0;
				dr_q    <= '0;
				dval_q  <= '0;
				fault_q <= '0;
			end
			OP_LATCH_OP: begin
				icode_q <= ram_rdata[7:4];
				fn_q    <= ram_rdata[3:0];
				ra_q    <= REG_NONE;
				rb_q    <= REG_NONE;
				npc_q   <= pc_q + 64'd1;
			end
			OP_LATCH_REG: begin
				ra_q  <= ram_rdata[7:4];
				rb_q  <= ram_rdata[3:0];
				npc_q <= npc_q + 64'd1;
			end
			OP_SETUP_NPC: cnt_q <= '0;
			OP_WORD_READ: begin
				// byte issued last cycle lands at the top, little endian
				if (cnt_q != '0) begin
					word_q <= {ram_rdata, word_q[63:8]};
				end
				cnt_q <= cnt_q + 1'b1;
			end
			OP_LATCH_VALC: begin
				valc_q <= word_q;
				npc_q  <= npc_q + WordStep;
			end
			OP_READ_A: a_q <= rd_val;
			OP_READ_B: b_q <= rd_val;
			OP_EXEC: begin
				t_q   <= exec_t;
				ncc_q <= ncc;
			end
			OP_SETUP_T: begin
				cnt_q  <= '0;
				word_q <= (icode_q == I_CALL) ? npc_q : a_q;
			end
			OP_WORD_WRITE: begin
				word_q <= {8'd0, word_q[63:8]};
				cnt_q  <= cnt_q + 1'b1;
			end
			OP_COMMIT: begin
				unique case (icode_q) inside
					I_CMOV: begin
						dv_q   <= cond;
						dr_q   <= cond ? rb_q : '0;
						dval_q <= cond ? a_q : '0;
					end
					I_IRMOV: begin
						dv_q   <= 1'b1;
						dr_q   <= rb_q;
						dval_q <= valc_q;
					end
					I_OPQ: begin
						dv_q   <= 1'b1;
						dr_q   <= rb_q;
						dval_q <= t_q;
					end
					I_MRMOV, I_POP: begin
						dv_q   <= 1'b1;
						dr_q   <= ra_q;
						dval_q <= word_q;
					end
					default: ;
				endcase
			end
			OP_ADR_PC:  fault_q <= pc_q;
			OP_ADR_NPC: fault_q <= npc_q;
			OP_ADR_T:   fault_q <= t_q;
			OP_PUBLISH: begin
				result_q.status          <= stat_q;
				result_q.program_counter <= pc_q;
				result_q.zero_flag       <= zf_q;
				result_q.sign_flag       <= sf_q;
				result_q.overflow_flag   <= of_q;
				result_q.dest_valid      <= dv_q;
				result_q.dest_reg        <= dr_q;
				result_q.dest_value      <= dval_q;
				result_q.stack_pointer   <= sp;
				result_q.fault_address   <= fault_q;
			end
			default: ;
		endcase
	end

	assign result = result_q;
endmodule

FILE: hw/rtl/y86ie_ctrl.sv
module y86ie_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	output logic                  result_valid,
	input  logic                  result_stall,
	input  y86ie_pkg::dp_status_t status,
	output y86ie_pkg::dp_op_t     op
);
	import y86ie_pkg::*;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_START,
		S_OPC,
		S_OPC_CHK,
		S_REGB,
		S_REG_CHK,
		S_VALC,
		S_VALC_LATCH,
		S_DECODE,
		S_READ_B,
		S_EXEC,
		S_MEMCHK,
		S_LOAD,
		S_STORE,
		S_COMMIT,
		S_PUBLISH
	} state_t;

	state_t state_q, state_d;
	logic   valid_q;

	always_comb begin
		state_d = state_q;
		op      = OP_NONE;
		unique case (state_q)
			S_CLEAR: begin
				op = OP_CLEAR;
				if (status.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (item_valid) begin
					op      = OP_CAPTURE;
					state_d = S_START;
				end
			end
			S_START: begin
				if (status.is_store || status.stopped) begin
					state_d = S_PUBLISH;
				end else if (status.pc_bad) begin
					op      = OP_ADR_PC;
					state_d = S_PUBLISH;
				end else begin
					op      = OP_RD_PC;
					state_d = S_OPC;
				end
			end
			S_OPC: begin
				op      = OP_LATCH_OP;
				state_d = S_OPC_CHK;
			end
			S_OPC_CHK: begin
				if (status.need_reg) begin
					if (status.npc_byte_bad) begin
						op      = OP_ADR_NPC;
						state_d = S_PUBLISH;
					end else begin
						op      = OP_RD_NPC;
						state_d = S_REGB;
					end
				end else if (status.need_valc) begin
					if (status.npc_word_bad) begin
						op      = OP_ADR_NPC;
						state_d = S_PUBLISH;
					end else begin
						op      = OP_SETUP_NPC;
						state_d = S_VALC;
					end
				end else begin
					state_d = S_DECODE;
				end
			end
			S_REGB: begin
				op      = OP_LATCH_REG;
				state_d = S_REG_CHK;
			end
			S_REG_CHK: begin
				if (status.need_valc) begin
					if (status.npc_word_bad) begin
						op      = OP_ADR_NPC;
						state_d = S_PUBLISH;
					end else begin
						op      = OP_SETUP_NPC;
						state_d = S_VALC;
					end
				end else begin
					state_d = S_DECODE;
				end
			end
			S_VALC: begin
				op = OP_WORD_READ;
				if (status.word_rd_done) begin
					state_d = S_VALC_LATCH;
				end
			end
			S_VALC_LATCH: begin
				op      = OP_LATCH_VALC;
				state_d = S_DECODE;
			end
			S_DECODE: begin
				if (status.ins_bad) begin
					op      = OP_SET_INS;
					state_d = S_PUBLISH;
				end else if (status.is_halt) begin
					op      = OP_SET_HLT;
					state_d = S_PUBLISH;
				end else begin
					op      = OP_READ_A;
					state_d = S_READ_B;
				end
			end
			S_READ_B: begin
				op      = OP_READ_B;
				state_d = S_EXEC;
			end
			S_EXEC: begin
				op      = OP_EXEC;
				state_d = S_MEMCHK;
			end
			S_MEMCHK: begin
				if (!status.mem_access) begin
					op      = OP_COMMIT;
					state_d = S_PUBLISH;
				end else if (status.addr_bad) begin
					op      = OP_ADR_T;
					state_d = S_PUBLISH;
				end else begin
					op      = OP_SETUP_T;
					state_d = status.mem_load ? S_LOAD : S_STORE;
				end
			end
			S_LOAD: begin
				op = OP_WORD_READ;
				if (status.word_rd_done) begin
					state_d = S_COMMIT;
				end
			end
			S_STORE: begin
				op = OP_WORD_WRITE;
				if (status.word_wr_done) begin
					state_d = S_COMMIT;
				end
			end
			S_COMMIT: begin
				op      = OP_COMMIT;
				state_d = S_PUBLISH;
			end
			S_PUBLISH: begin
				// wait until the output register is free or being emptied
				if (!valid_q || !result_stall) begin
					op      = OP_PUBLISH;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (op == OP_PUBLISH) begin
				valid_q <= 1'b1;
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = valid_q;
endmodule

FILE: hw/rtl/y86_instruction_executor_core.sv
// Sequential Y86-64 core with a byte-wide memory of MEM_BYTES bytes. An item with command 0
// stores data_byte at address (ignored beyond memory); an item with command 1 executes one
// instruction at pc, or just reports the stopped state or an out-of-range pc. The memory
// is accessed one byte at a time: the opcode and register bytes are read singly, and an
// 8-byte constant or a data word is read or stored byte by byte. After reset the memory
// is zeroed one byte per cycle, with item_stall high throughout. Each item gives one
// result; a new item is taken while the previous result still waits on result_stall, and
// the next result then waits until that one has gone.
module y86_instruction_executor_core #(
	parameter int MEM_BYTES = 4096
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	output logic                     item_stall,
	input  y86ie_pkg::y86ie_item_t   item,
	output logic                     result_valid,
	input  logic                     result_stall,
	output y86ie_pkg::y86ie_result_t result
);
	import y86ie_pkg::*;

	dp_op_t     op;
	dp_status_t status;

	y86ie_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.op           (op)
	);

	y86ie_dp #(.MEM_BYTES(MEM_BYTES)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.item   (item),
		.status (status),
		.result (result)
	);
endmodule

FILE: hw/rtl/y86ie_checker.sv
`include "y86_instruction_executor_core_defines.svh"

module y86ie_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     item_valid,
	input logic                     item_stall,
	input y86ie_pkg::y86ie_item_t   item,
	input logic                     result_valid,
	input logic                     result_stall,
	input y86ie_pkg::y86ie_result_t result
);
	import y86ie_pkg::*;

	logic       in_xfer, out_xfer;
	logic [1:0] cnt_q;
	logic       stop_q;
	logic [1:0] stop_stat_q;
	logic       res_hold;

	assign in_xfer  = item_valid && !item_stall;
	assign out_xfer = result_valid && !result_stall;
	assign res_hold = result_valid && result_stall;

	// items in flight, taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			stop_q      <= 1'b0;
			stop_stat_q <= ST_AOK;
		end else begin
			cnt_q <= cnt_q + 2'(in_xfer) - 2'(out_xfer);
			if (out_xfer && (result.status != ST_AOK) && !stop_q) begin
				stop_q      <= 1'b1;
				stop_stat_q <= result.status;
			end
		end
	end

	`Y86_ASSERT_NEXT(a_result_hold, clk, arst_n, res_hold, result_valid && $stable(result))
	`Y86_ASSERT_IMPL(a_result_has_item, clk, arst_n, out_xfer, cnt_q != 2'd0)
	`Y86_ASSERT_IMPL(a_in_flight_bound, clk, arst_n, in_xfer, cnt_q != 2'd2)
	`Y86_ASSERT_IMPL(a_stop_sticky, clk, arst_n, result_valid && stop_q, result.status == stop_stat_q)
endmodule

bind y86_instruction_executor_core y86ie_checker u_checker (.*);
